FILE: rtl/assert_macros.svh
// Assertion macros shared by the occupancy map RTL.
// Each macro checks an implication on the rising edge of i_clk, held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/grom_pkg.sv
// Shared types, codes and widths for the grid rectangle occupancy map.
// No dependencies; used by every module of the block.
package grom_pkg;

    localparam int MAP_ROWS_DEF = 64;
    localparam int MAP_COLS_DEF = 64;

    localparam int LEN_W  = 12;  // real length and width of an item
    localparam int SIZE_W = 8;   // cell size registers
    localparam int IDX_W  = 6;   // corner row and column
    localparam int CNT_W  = 4;   // divider step counter
    localparam int SUM_W  = 13;  // corner plus span

    localparam logic [1:0] CMD_CHECK   = 2'd0;
    localparam logic [1:0] CMD_OCCUPY  = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_HIT   = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic REG_CELL_SIZE_X = 1'b0;
    localparam logic REG_CELL_SIZE_Y = 1'b1;

    typedef enum logic [2:0] {
        C_IDLE,
        C_DIV,
        C_CHECK,
        C_SWEEP,
        C_DONE
    } t_ctl_state;

    typedef enum logic [1:0] {
        M_CLEAR,
        M_IDLE,
        M_SWEEP,
        M_DRAIN
    } t_map_state;

    typedef struct packed {
        logic ready;
        logic done;
        logic hit;
    } t_map_stat;

endpackage

FILE: rtl/grom_div.sv
// Restoring divider: 12-bit dividend by an 8-bit cell size, one quotient bit per cycle.
// Depends on grom_pkg for widths.
module grom_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [grom_pkg::LEN_W-1:0]  i_dividend,
    input  logic [grom_pkg::SIZE_W-1:0] i_divisor,
    output logic [grom_pkg::LEN_W-1:0]  o_quot,
    output logic                        o_busy
);

    logic                        r_busy;
    logic [grom_pkg::CNT_W-1:0]  r_cnt;
    logic [grom_pkg::SIZE_W-1:0] r_rem;
    logic [grom_pkg::LEN_W-1:0]  r_quo;
    logic [grom_pkg::SIZE_W-1:0] r_div;

    logic [grom_pkg::SIZE_W:0]   trial;
    logic [grom_pkg::SIZE_W:0]   diff;
    logic                        ge;
    logic [grom_pkg::SIZE_W-1:0] n_rem;

    // The remainder stays below the divisor, so the shifted trial fits in one extra bit.
    always_comb begin
        trial = {r_rem, r_quo[grom_pkg::LEN_W-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[grom_pkg::SIZE_W-1:0] : trial[grom_pkg::SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + grom_pkg::CNT_W'(1);
            if (r_cnt == grom_pkg::CNT_W'(grom_pkg::LEN_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // A cell size of zero divides as one.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= (i_divisor == '0) ? grom_pkg::SIZE_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[grom_pkg::LEN_W-2:0], ge};
        end
    end

    assign o_quot = r_quo;
    assign o_busy = r_busy;

endmodule

FILE: rtl/grom_map.sv
// Occupancy bitmap memory with its clearing pass and the per-row read-modify-write sweep.
// Depends on grom_pkg for command codes, state and status types.
module grom_map #(
    parameter int MAP_ROWS = grom_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = grom_pkg::MAP_COLS_DEF,
    localparam int AW = $clog2(MAP_ROWS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_cmd,
    input  logic [AW-1:0]       i_first,
    input  logic [AW-1:0]       i_last,
    input  logic [MAP_COLS-1:0] i_mask,
    output grom_pkg::t_map_stat o_stat
);

    logic [MAP_COLS-1:0] mem [MAP_ROWS];

    grom_pkg::t_map_state r_state;
    grom_pkg::t_map_state n_state;

    logic [AW-1:0]       r_row;
    logic [AW-1:0]       r_last;
    logic [1:0]          r_cmd;
    logic [MAP_COLS-1:0] r_mask;
    logic [MAP_COLS-1:0] r_q;
    logic                r_q_valid;
    logic [AW-1:0]       r_q_addr;
    logic                r_hit;

    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [MAP_COLS-1:0] wr_data;
    logic                row_hit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            grom_pkg::M_CLEAR: begin
                if (r_row == AW'(MAP_ROWS - 1)) begin
                    n_state = grom_pkg::M_IDLE;
                end
            end
            grom_pkg::M_IDLE: begin
                if (i_start) begin
                    n_state = grom_pkg::M_SWEEP;
                end
            end
            grom_pkg::M_SWEEP: begin
                if (r_row == r_last) begin
                    n_state = grom_pkg::M_DRAIN;
                end
            end
            grom_pkg::M_DRAIN: begin
                n_state = grom_pkg::M_IDLE;
            end
            default: begin
                n_state = grom_pkg::M_IDLE;
            end
        endcase
    end

    // A row read in one cycle is modified and written back in the next, while the
    // following row is read. Rows within one sweep are distinct, so nothing overlaps.
    always_comb begin
        rd_en   = (r_state == grom_pkg::M_SWEEP);
        row_hit = r_q_valid && ((r_q & r_mask) != '0);
        wr_en   = 1'b0;
        wr_addr = r_q_addr;
        wr_data = r_q;
        if (r_state == grom_pkg::M_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_row;
            wr_data = '0;
        end else if (r_q_valid) begin
            case (r_cmd)
                grom_pkg::CMD_OCCUPY: begin
                    wr_en   = 1'b1;
                    wr_data = r_q | r_mask;
                end
                grom_pkg::CMD_RELEASE: begin
                    wr_en   = 1'b1;
                    wr_data = r_q & ~r_mask;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
        o_stat.ready = (r_state == grom_pkg::M_IDLE);
        o_stat.done  = (r_state == grom_pkg::M_DRAIN);
        o_stat.hit   = r_hit | row_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= grom_pkg::M_CLEAR;
            r_row     <= '0;
            r_q_valid <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_q_valid <= (r_state == grom_pkg::M_SWEEP);
            if (r_state == grom_pkg::M_IDLE) begin
                if (i_start) begin
                    r_row <= i_first;
                    r_hit <= 1'b0;
                end
            end else if (r_state == grom_pkg::M_CLEAR || r_state == grom_pkg::M_SWEEP) begin
                r_row <= r_row + AW'(1);
            end
            if (row_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == grom_pkg::M_IDLE && i_start) begin
            r_last <= i_last;
            r_cmd  <= i_cmd;
            r_mask <= i_mask;
        end
        r_q_addr <= r_row;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= mem[r_row];
        end
    end

endmodule

FILE: rtl/grid_rectangle_occupancy_map.sv
// Channel     | Direction | Beat contents (lowest bits first)
// s_axis      | in        | tdata: item_length, item_width, corner_row, corner_col; tuser: cmd, rotated
// m_axis      | out       | tdata: status
// cfg         | in        | index 0 cell_size_x, index 1 cell_size_y
//
// One item at a time: both spans are divided (12 steps and a handoff), the range is checked,
// then each covered row is read and written back and the sweep drains, the output register
// is loaded and the controller returns to idle. Out-of-range items skip the sweep.
// After reset the map is cleared one row per cycle before s_axis is ready.
// A result waiting on m_axis lets the next item run; its own result and s_axis then wait.
// Depends on grom_pkg, grom_div, grom_map and assert_macros.svh.
`include "assert_macros.svh"

module grid_rectangle_occupancy_map #(
    parameter int MAP_ROWS = grom_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = grom_pkg::MAP_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // item_length, item_width, corner_row, corner_col
    input  logic [2:0]  i_s_axis_tuser,   // cmd, rotated
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // status
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int AW = $clog2(MAP_ROWS);

    grom_pkg::t_ctl_state r_state;
    grom_pkg::t_ctl_state n_state;

    logic [grom_pkg::SIZE_W-1:0] r_cell_size_x;
    logic [grom_pkg::SIZE_W-1:0] r_cell_size_y;
    logic [1:0]                  r_cmd;
    logic [grom_pkg::IDX_W-1:0]  r_row;
    logic [grom_pkg::IDX_W-1:0]  r_col;
    logic [1:0]                  r_status;
    logic                        r_out_valid;
    logic [1:0]                  r_out_status;

    logic [grom_pkg::LEN_W-1:0]  in_length;
    logic [grom_pkg::LEN_W-1:0]  in_width;
    logic                        in_rotated;
    logic                        accept;
    logic                        out_free;
    logic                        out_load;
    logic                        map_start;
    logic                        out_of_range;

    logic [grom_pkg::LEN_W-1:0]  q_row;
    logic [grom_pkg::LEN_W-1:0]  q_col;
    logic                        busy_row;
    logic                        busy_col;
    logic [grom_pkg::SUM_W-1:0]  row_end;
    logic [grom_pkg::SUM_W-1:0]  col_end;
    logic [MAP_COLS-1:0]         col_mask;
    grom_pkg::t_map_stat         map_stat;

    assign in_length  = i_s_axis_tdata[11:0];
    assign in_width   = i_s_axis_tdata[23:12];
    assign in_rotated = i_s_axis_tuser[2];
    assign accept     = i_s_axis_tvalid && o_s_axis_tready;

    grom_div u_div_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (in_rotated ? in_width : in_length),
        .i_divisor  (r_cell_size_x),
        .o_quot     (q_row),
        .o_busy     (busy_row)
    );

    grom_div u_div_col (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (in_rotated ? in_length : in_width),
        .i_divisor  (r_cell_size_y),
        .o_quot     (q_col),
        .o_busy     (busy_col)
    );

    // Inclusive spans: the last covered row and column, checked against the map size.
    always_comb begin
        row_end      = grom_pkg::SUM_W'(r_row) + grom_pkg::SUM_W'(q_row);
        col_end      = grom_pkg::SUM_W'(r_col) + grom_pkg::SUM_W'(q_col);
        out_of_range = (row_end >= grom_pkg::SUM_W'(MAP_ROWS))
                    || (col_end >= grom_pkg::SUM_W'(MAP_COLS));
        for (int c = 0; c < MAP_COLS; c++) begin
            col_mask[c] = (grom_pkg::SUM_W'(c) >= grom_pkg::SUM_W'(r_col))
                       && (grom_pkg::SUM_W'(c) <= col_end);
        end
    end

    grom_map #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (map_start),
        .i_cmd   (r_cmd),
        .i_first (AW'(r_row)),
        .i_last  (AW'(row_end)),
        .i_mask  (col_mask),
        .o_stat  (map_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            grom_pkg::C_IDLE: begin
                if (accept) begin
                    n_state = grom_pkg::C_DIV;
                end
            end
            grom_pkg::C_DIV: begin
                if (!busy_row) begin
                    n_state = grom_pkg::C_CHECK;
                end
            end
            grom_pkg::C_CHECK: begin
                n_state = out_of_range ? grom_pkg::C_DONE : grom_pkg::C_SWEEP;
            end
            grom_pkg::C_SWEEP: begin
                if (map_stat.done) begin
                    n_state = grom_pkg::C_DONE;
                end
            end
            grom_pkg::C_DONE: begin
                if (out_free) begin
                    n_state = grom_pkg::C_IDLE;
                end
            end
            default: begin
                n_state = grom_pkg::C_IDLE;
            end
        endcase
    end

    always_comb begin
        out_free        = !r_out_valid || i_m_axis_tready;
        o_s_axis_tready = (r_state == grom_pkg::C_IDLE) && map_stat.ready;
        map_start       = (r_state == grom_pkg::C_CHECK) && !out_of_range;
        out_load        = (r_state == grom_pkg::C_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= grom_pkg::C_IDLE;
            r_cell_size_x <= grom_pkg::SIZE_W'(1);
            r_cell_size_y <= grom_pkg::SIZE_W'(1);
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_addr == grom_pkg::REG_CELL_SIZE_X) begin
                    r_cell_size_x <= i_cfg_wdata;
                end else begin
                    r_cell_size_y <= i_cfg_wdata;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Only a check (or the unused code) reports occupied cells.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_s_axis_tuser[1:0];
            r_row <= i_s_axis_tdata[29:24];
            r_col <= i_s_axis_tdata[35:30];
        end
        if (r_state == grom_pkg::C_CHECK && out_of_range) begin
            r_status <= grom_pkg::STAT_RANGE;
        end else if (r_state == grom_pkg::C_SWEEP && map_stat.done) begin
            if (map_stat.hit && r_cmd != grom_pkg::CMD_OCCUPY
                    && r_cmd != grom_pkg::CMD_RELEASE) begin
                r_status <= grom_pkg::STAT_HIT;
            end else begin
                r_status <= grom_pkg::STAT_OK;
            end
        end
        if (out_load) begin
            r_out_status <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_status};

    `ASSERT_SAME(a_done_in_sweep, map_stat.done, r_state == grom_pkg::C_SWEEP)
    `ASSERT_SAME(a_div_lockstep, r_state == grom_pkg::C_DIV, busy_row == busy_col)
    `ASSERT_NEXT(a_write_no_hit, (r_state == grom_pkg::C_SWEEP) && map_stat.done && (r_cmd == grom_pkg::CMD_OCCUPY || r_cmd == grom_pkg::CMD_RELEASE), r_status == grom_pkg::STAT_OK)
    `ASSERT_NEXT(a_accept_starts_div, accept, (r_state == grom_pkg::C_DIV) && busy_row)

endmodule

FILE: tb/sv/tb_grid_rectangle_occupancy_map.sv
// Self-checking testbench for grid_rectangle_occupancy_map: drives rectangle commands on
// the input stream and checks every status beat against a bitmap predictor kept here.
// Depends on grom_pkg and the RTL of the block.
module tb_grid_rectangle_occupancy_map;

    localparam int          GRID_ROWS   = grom_pkg::MAP_ROWS_DEF;
    localparam int          GRID_COLS   = grom_pkg::MAP_COLS_DEF;
    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_s_axis_tvalid  = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata   = '0;   // item_length, item_width, corner_row, corner_col
    logic [2:0]  i_s_axis_tuser   = '0;   // cmd, rotated
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready  = 1'b0;
    logic [7:0]  o_m_axis_tdata;          // status
    logic        i_cfg_we         = 1'b0;
    logic        i_cfg_addr       = 1'b0;
    logic [7:0]  i_cfg_wdata      = '0;

    // Predictor state: one word per grid row, bit c set when cell c is taken.
    bit [63:0]  occupied_cells [GRID_ROWS];
    bit [7:0]   cell_size_x = 8'd1;
    bit [7:0]   cell_size_y = 8'd1;
    bit [1:0]   expected_status [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    grid_rectangle_occupancy_map dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Applies one command to the predictor map and returns the status it should produce.
    function automatic bit [1:0] apply_rectangle(input bit [1:0] cmd, input bit [11:0] len,
                                                 input bit [11:0] wid, input bit [5:0] row,
                                                 input bit [5:0] col, input bit rot);
        int        sx, sy, row_span, col_span;
        bit [63:0] col_mask;
        bit [1:0]  status;
        sx = (cell_size_x == 0) ? 1 : int'(cell_size_x);
        sy = (cell_size_y == 0) ? 1 : int'(cell_size_y);
        row_span = int'(rot ? wid : len) / sx;
        col_span = int'(rot ? len : wid) / sy;
        if (int'(row) + row_span >= GRID_ROWS || int'(col) + col_span >= GRID_COLS)
            return grom_pkg::STAT_RANGE;
        col_mask = (col_span + 1 >= 64) ? '1 : ((64'd1 << (col_span + 1)) - 64'd1);
        col_mask = col_mask << col;
        status = grom_pkg::STAT_OK;
        for (int r = int'(row); r <= int'(row) + row_span; r++) begin
            case (cmd)
                grom_pkg::CMD_OCCUPY:  occupied_cells[r] |= col_mask;
                grom_pkg::CMD_RELEASE: occupied_cells[r] &= ~col_mask;
                default: begin
                    if ((occupied_cells[r] & col_mask) != 0)
                        status = grom_pkg::STAT_HIT;
                end
            endcase
        end
        return status;
    endfunction

    // Offers one beat, holding it until the block takes it. Valid stays high on return so
    // the next beat can follow directly; end_burst lowers it.
    task automatic send_rect(input bit [1:0] cmd, input bit [11:0] len, input bit [11:0] wid,
                             input bit [5:0] row, input bit [5:0] col, input bit rot);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, col, row, wid, len};
        i_s_axis_tuser  <= {rot, cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_status = {expected_status, apply_rectangle(cmd, len, wid, row, col, rot)};
    endtask

    // Lowers valid and waits until every expected status has come back.
    task automatic end_burst();
        i_s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cell_size(input logic addr, input bit [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (addr == grom_pkg::REG_CELL_SIZE_X)
            cell_size_x = value;
        else
            cell_size_y = value;
    endtask

    task automatic set_cell_sizes(input bit [7:0] size_x, input bit [7:0] size_y);
        end_burst();
        write_cell_size(grom_pkg::REG_CELL_SIZE_X, size_x);
        write_cell_size(grom_pkg::REG_CELL_SIZE_Y, size_y);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly rectangles that fit the grid under the current cell sizes, so the map fills
    // and drains; the rest are raw field values, most of them out of range.
    task automatic send_random_rect();
        bit [1:0]  cmd;
        bit [11:0] len, wid;
        bit [5:0]  row, col;
        bit        rot;
        int        pick, sx, sy, row_span, col_span, along_rows, along_cols;
        pick = $urandom_range(99);
        cmd = (pick < 33) ? grom_pkg::CMD_CHECK : (pick < 63) ? grom_pkg::CMD_OCCUPY :
              (pick < 95) ? grom_pkg::CMD_RELEASE : CMD_UNUSED;
        rot = 1'($urandom_range(1));
        if ($urandom_range(99) < 12) begin
            len = 12'($urandom);
            wid = 12'($urandom);
            row = 6'($urandom);
            col = 6'($urandom);
        end else begin
            sx = (cell_size_x == 0) ? 1 : int'(cell_size_x);
            sy = (cell_size_y == 0) ? 1 : int'(cell_size_y);
            row_span = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
            col_span = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(7);
            if (row_span > 4095 / sx) row_span = 4095 / sx;
            if (col_span > 4095 / sy) col_span = 4095 / sy;
            row = 6'($urandom_range(GRID_ROWS - 1 - row_span));
            col = 6'($urandom_range(GRID_COLS - 1 - col_span));
            along_rows = row_span * sx + $urandom_range(sx - 1);
            along_cols = col_span * sy + $urandom_range(sy - 1);
            if (along_rows > 4095) along_rows = 4095;
            if (along_cols > 4095) along_cols = 4095;
            len = 12'(rot ? along_cols : along_rows);
            wid = 12'(rot ? along_rows : along_cols);
        end
        send_rect(cmd, len, wid, row, col, rot);
    endtask

    task automatic test_directed_cases();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_rect(grom_pkg::CMD_CHECK,   12'd0,    12'd0,    6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_OCCUPY,  12'd63,   12'd63,   6'd0,  6'd0,  1'b0);  // whole grid
        send_rect(grom_pkg::CMD_CHECK,   12'd0,    12'd0,    6'd10, 6'd20, 1'b0);
        send_rect(CMD_UNUSED,            12'd0,    12'd0,    6'd63, 6'd63, 1'b0);
        send_rect(grom_pkg::CMD_RELEASE, 12'd63,   12'd63,   6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd63,   12'd63,   6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd1,    12'd0,    6'd63, 6'd0,  1'b0);  // rows overflow
        send_rect(grom_pkg::CMD_CHECK,   12'd0,    12'd1,    6'd0,  6'd63, 1'b0);  // cols overflow
        send_rect(grom_pkg::CMD_OCCUPY,  12'd4095, 12'd4095, 6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd0,    12'd0,    6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_RELEASE, 12'd3,    12'd1,    6'd5,  6'd5,  1'b0);  // already free
        send_rect(grom_pkg::CMD_OCCUPY,  12'd5,    12'd20,   6'd2,  6'd40, 1'b1);
        send_rect(grom_pkg::CMD_CHECK,   12'd0,    12'd0,    6'd22, 6'd45, 1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd0,    12'd0,    6'd6,  6'd46, 1'b0);
        send_rect(grom_pkg::CMD_OCCUPY,  12'd5,    12'd20,   6'd2,  6'd40, 1'b1);  // already taken
        send_rect(grom_pkg::CMD_OCCUPY,  12'd63,   12'd0,    6'd0,  6'd0,  1'b1);
        send_rect(grom_pkg::CMD_OCCUPY,  12'd0,    12'd63,   6'd63, 6'd0,  1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd63,   12'd0,    6'd63, 6'd0,  1'b1);
        send_rect(grom_pkg::CMD_RELEASE, 12'd63,   12'd63,   6'd0,  6'd0,  1'b1);
        send_rect(CMD_UNUSED,            12'd63,   12'd63,   6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_OCCUPY,  12'd0,    12'd0,    6'd63, 6'd63, 1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd1,    12'd1,    6'd62, 6'd62, 1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd4095, 12'd0,    6'd0,  6'd0,  1'b1);
        send_rect(grom_pkg::CMD_RELEASE, 12'd1,    12'd0,    6'd63, 6'd63, 1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd0,    12'd0,    6'd63, 6'd63, 1'b0);
        end_burst();
    endtask

    task automatic test_cell_size_extremes();
        set_cell_sizes(8'd255, 8'd255);
        send_rect(grom_pkg::CMD_OCCUPY,  12'd4095, 12'd4095, 6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd254,  12'd254,  6'd16, 6'd16, 1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd4095, 12'd0,    6'd47, 6'd47, 1'b1);
        send_rect(grom_pkg::CMD_RELEASE, 12'd4095, 12'd4095, 6'd0,  6'd0,  1'b1);
        set_cell_sizes(8'd0, 8'd0);   // zero acts as one
        send_rect(grom_pkg::CMD_CHECK,   12'd63,   12'd0,    6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd64,   12'd0,    6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_OCCUPY,  12'd0,    12'd63,   6'd7,  6'd0,  1'b0);
        set_cell_sizes(8'd255, 8'd1);
        send_rect(grom_pkg::CMD_CHECK,   12'd2048, 12'd2048, 6'd7,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd4095, 12'd63,   6'd0,  6'd0,  1'b0);
        set_cell_sizes(8'd1, 8'd255);
        send_rect(grom_pkg::CMD_RELEASE, 12'd63,   12'd4095, 6'd0,  6'd0,  1'b0);
        send_rect(grom_pkg::CMD_CHECK,   12'd63,   12'd4095, 6'd0,  6'd0,  1'b1);
        end_burst();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct,
                                     input bit [7:0] size_x, input bit [7:0] size_y);
        set_cell_sizes(size_x, size_y);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (count) send_random_rect();
        end_burst();
    endtask

    // The receiver holds off while the sender keeps offering, so the block backs up.
    task automatic test_output_hold_off();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(posedge i_clk);
        hold_left <= 400;
        repeat (16) send_random_rect();
        end_burst();
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_status.size() == 0) begin
                report_mismatch($sformatf("status %0d beat with none expected",
                                          o_m_axis_tdata[1:0]));
            end else begin
                if (o_m_axis_tdata[1:0] != expected_status[0])
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_m_axis_tdata[1:0], expected_status[0]));
                void'(expected_status.pop_front());
            end
        end
        i_m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL grid_rectangle_occupancy_map");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_cell_size_extremes();
        test_random_phase(260, 0, 0, 8'd1, 8'd1);
        test_random_phase(250, 81, 0, 8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
        test_random_phase(250, 0, 81, 8'd3, 8'd2);
        test_output_hold_off();
        test_random_phase(250, 28, 28, 8'($urandom_range(1, 16)),
                          8'($urandom_range(0, 16)));
        test_random_phase(80, 0, 0, 8'd255, 8'd255);
        repeat (120) @(posedge i_clk);
        if (mismatch_count == 0 && expected_status.size() == 0)
            $display("PASS grid_rectangle_occupancy_map");
        else
            $display("FAIL grid_rectangle_occupancy_map");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/grom_pkg.sv
rtl/grom_div.sv
rtl/grom_map.sv
rtl/grid_rectangle_occupancy_map.sv
tb/sv/tb_grid_rectangle_occupancy_map.sv
